### design/clh_pkg.sv
// ----------------------------------------------------------------------------
// clh_pkg: shared types and constants of the code lock
// Defaults, reset values, register indexes, status codes and the result word.
// ----------------------------------------------------------------------------
package clh_pkg;

  // defaults for the top level parameters
  localparam int HISTORY_DEPTH_DEF = 5;
  localparam int CODE_BITS_DEF     = 32;

  // fixed field widths
  localparam int ENTRY_W  = 32;
  localparam int TRIES_W  = 4;
  localparam int STATUS_W = 3;
  localparam int MODE_W   = 2;
  localparam int OUT_W    = 16;

  // reset values
  localparam logic [ENTRY_W-1:0] RESET_CODE  = 32'd12345;
  localparam logic [ENTRY_W-1:0] RESET_ADMIN = 32'd54321;
  localparam logic [TRIES_W-1:0] RESET_TRIES = 4'd3;
  localparam logic [TRIES_W-1:0] TRIES_SAT   = 4'd15;

  // configuration register indexes
  localparam logic CFG_ADMIN_CODE = 1'b0;
  localparam logic CFG_MAX_TRIES  = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_USER_OK     = 3'd0,
    ST_WRONG       = 3'd1,
    ST_LOCKED      = 3'd2,
    ST_ADMIN_WRONG = 3'd3,
    ST_ADMIN_OK    = 3'd4,
    ST_REUSED      = 3'd5,
    ST_NEW_SET     = 3'd6
  } status_t;

  // one result word, status in the lowest bits
  typedef struct packed {
    logic [MODE_W-1:0]  mode_now;
    logic [TRIES_W-1:0] tries_used;
    status_t            status;
  } result_t;

endpackage

### design/clh_ring.sv
// ----------------------------------------------------------------------------
// clh_ring: ring of recently used codes
// Stores the last codes with valid marks and matches a lookup code against
// all valid entries in parallel.
// ----------------------------------------------------------------------------
module clh_ring
  import clh_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int CODE_BITS     = CODE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [CODE_BITS-1:0] push_code,
  input  logic [CODE_BITS-1:0] lookup_code,
  output logic                 hit
);

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

  logic [CODE_BITS-1:0]     codes_r [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid_r;
  logic [PTR_W-1:0]         ptr_r;
  logic [HISTORY_DEPTH-1:0] match;

  // pointer and valid marks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else if (push) begin
      valid_r[ptr_r] <= 1'b1;
      ptr_r          <= (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
    end
  end

  // entry storage, overwrites the oldest entry once full
  always_ff @(posedge clk) begin
    if (push) begin
      codes_r[ptr_r] <= push_code;
    end
  end

  // parallel compare against every valid entry
  always_comb begin
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      match[i] = valid_r[i] && (codes_r[i] == lookup_code);
    end
  end

  assign hit = |match;

endmodule

### design/clh_skid.sv
// ----------------------------------------------------------------------------
// clh_skid: two-entry result buffer
// Holds the result word for the output side and a second word so that the
// input side keeps taking words while a result waits.
// ----------------------------------------------------------------------------
module clh_skid
  import clh_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_word,
  output logic    ready,
  output logic    out_vld,
  output result_t out_word,
  input  logic    out_rdy
);

  logic    main_vld_r;
  logic    skid_vld_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop     = main_vld_r && out_rdy;
  assign ready   = !skid_vld_r;
  assign out_vld = main_vld_r;
  assign out_word = main_r;

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      main_vld_r <= 1'b1;
      if (main_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      main_vld_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_vld_r || pop) begin
        main_r <= push_word;
      end else begin
        skid_r <= push_word;
      end
    end
  end

endmodule

### design/code_lock_with_history.sv
// ----------------------------------------------------------------------------
// code_lock_with_history: code lock with lockout and a ring of used codes
// Checks keyed codes against the current or admin code by mode, counts
// failed tries, locks out, and refuses new codes found in the ring.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tdata[31:0] entered_code
//  out_    | out | out_tvalid/tready  | tdata[2:0] status, [6:3] tries_used,
//          |     |                    | [8:7] mode_now, [15:9] zero
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
//  One word per cycle while in_tready is high; its result is registered and
//  offered once earlier results are taken. Mode, try count and ring update as
//  the word is taken, so words may follow back to back. A two-word result buffer
//  keeps in_tready high while one result waits, low with both words full.
//  Synchronous active-low reset, no clearing pass: the ring uses valid marks.
// ----------------------------------------------------------------------------
module code_lock_with_history
  import clh_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int CODE_BITS     = CODE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input words
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [ENTRY_W-1:0] in_tdata,   // [31:0] entered_code
  // result words
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OUT_W-1:0]   out_tdata,  // [2:0] status, [6:3] tries_used,
                                         // [8:7] mode_now, [15:9] zero
  // configuration writes
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [ENTRY_W-1:0] cfg_wdata
);

  typedef enum logic [MODE_W-1:0] {
    MODE_USER   = 2'd0,
    MODE_LOCKED = 2'd1,
    MODE_NEW    = 2'd2
  } mode_t;

  mode_t                mode_r, mode_nxt;
  logic [TRIES_W-1:0]   fail_r, fail_nxt, fail_inc;
  logic [CODE_BITS-1:0] cur_r, cur_nxt;
  logic [CODE_BITS-1:0] admin_r;
  logic [TRIES_W-1:0]   max_tries_r;
  logic [CODE_BITS-1:0] code;
  logic                 in_fire;
  logic                 ring_push;
  logic                 ring_hit;
  status_t              status;
  result_t              res_word;
  result_t              out_word;

  assign in_fire  = in_tvalid && in_tready;
  assign code     = CODE_BITS'(in_tdata);
  assign fail_inc = (fail_r == TRIES_SAT) ? TRIES_SAT : fail_r + TRIES_W'(1);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      admin_r     <= CODE_BITS'(RESET_ADMIN);
      max_tries_r <= RESET_TRIES;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADMIN_CODE: admin_r     <= CODE_BITS'(cfg_wdata);
        CFG_MAX_TRIES:  max_tries_r <= cfg_wdata[TRIES_W-1:0];
        default:        ;
      endcase
    end
  end

  // next mode, try count and status
  always_comb begin
    mode_nxt  = mode_r;
    fail_nxt  = fail_r;
    cur_nxt   = cur_r;
    ring_push = 1'b0;
    status    = ST_USER_OK;
    unique case (mode_r)
      MODE_LOCKED: begin
        if (code == admin_r) begin
          status    = ST_ADMIN_OK;
          ring_push = in_fire;
          mode_nxt  = MODE_NEW;
        end else begin
          status = ST_ADMIN_WRONG;
        end
      end
      MODE_NEW: begin
        if (ring_hit) begin
          status = ST_REUSED;
        end else begin
          status   = ST_NEW_SET;
          cur_nxt  = code;
          fail_nxt = '0;
          mode_nxt = MODE_USER;
        end
      end
      default: begin
        if (code == cur_r) begin
          status    = ST_USER_OK;
          ring_push = in_fire;
          mode_nxt  = MODE_NEW;
        end else begin
          fail_nxt = fail_inc;
          if (fail_inc >= max_tries_r) begin
            status   = ST_LOCKED;
            mode_nxt = MODE_LOCKED;
          end else begin
            status   = ST_WRONG;
            mode_nxt = MODE_USER;
          end
        end
      end
    endcase
  end

  // lock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_USER;
      fail_r <= '0;
      cur_r  <= CODE_BITS'(RESET_CODE);
    end else if (in_fire) begin
      mode_r <= mode_nxt;
      fail_r <= fail_nxt;
      cur_r  <= cur_nxt;
    end
  end

  // history of used codes
  clh_ring #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CODE_BITS     (CODE_BITS)
  ) u_ring (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (ring_push),
    .push_code   (cur_r),
    .lookup_code (code),
    .hit         (ring_hit)
  );

  // result word
  always_comb begin
    res_word.status     = status;
    res_word.tries_used = fail_nxt;
    res_word.mode_now   = MODE_W'(mode_nxt);
  end

  clh_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .push_word (res_word),
    .ready     (in_tready),
    .out_vld   (out_tvalid),
    .out_word  (out_word),
    .out_rdy   (out_tready)
  );

  assign out_tdata = OUT_W'(out_word);

  // a new code set ends the session with a cleared try count
  a_new_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && mode_r == MODE_NEW && !ring_hit |=> fail_r == '0 && mode_r == MODE_USER)
    else $error("try count not cleared after new code");

  // lock state moves only with an accepted word
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r) && $stable(fail_r) && $stable(cur_r))
    else $error("lock state changed without input word");

  // the ring is written only on the way into new-code entry
  a_push_to_new: assert property (@(posedge clk) disable iff (!rst_n)
    ring_push |=> mode_r == MODE_NEW)
    else $error("ring push without entering new-code mode");

endmodule
